// ----- hdl/rinv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rinv_pkg
// Shared constants and controller/datapath interface types for the radical
// inverse block.
// ----------------------------------------------------------------------------
package rinv_pkg;

  // sizing of the arithmetic
  localparam int INDEX_BITS    = 31;
  localparam int FRACTION_BITS = 32;
  localparam int MAX_RADIX     = 16;

  // stream field widths
  localparam int SAMPLE_INDEX_W = 31;
  localparam int RADIX_W        = 5;
  localparam int FRACTION_W     = 32;
  localparam int IN_TDATA_W     = ((SAMPLE_INDEX_W + RADIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((FRACTION_W + 7) / 8) * 8;

  // derived widths
  localparam int BASE_W    = $clog2(MAX_RADIX + 1);
  localparam int DEN_W     = INDEX_BITS + BASE_W;
  localparam int DIV_CNT_W = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
  localparam int RECIP_DEPTH = 2 ** BASE_W;

  localparam int MIN_RADIX = 2;

  typedef struct packed {
    logic load;
    logic mul;
    logic digit;
    logic div_step;
    logic out_load;
  } rinv_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic q_zero;
  } rinv_sts_t;

endpackage

// ----- hdl/rinv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rinv_datapath
// Digit extraction by reciprocal multiply, digit reversal and a bit-serial
// restoring divider for the fixed-point fraction.
// ----------------------------------------------------------------------------
module rinv_datapath (
  input  logic                           clk,
  input  logic [rinv_pkg::IN_TDATA_W-1:0] in_word,
  input  rinv_pkg::rinv_cmd_t            cmd,
  output rinv_pkg::rinv_sts_t            sts,
  output logic [rinv_pkg::FRACTION_W-1:0] fraction
);

  localparam int IB  = rinv_pkg::INDEX_BITS;
  localparam int BW  = rinv_pkg::BASE_W;
  localparam int DW  = rinv_pkg::DEN_W;
  localparam int FB  = rinv_pkg::FRACTION_BITS;
  localparam int SIW = rinv_pkg::SAMPLE_INDEX_W;
  localparam int RW  = rinv_pkg::RADIX_W;
  localparam int QW  = IB + BW;

  // reciprocal table: floor(2^IB / b), index one short of exact at most
  logic [IB-1:0] recip_tab [rinv_pkg::RECIP_DEPTH];

  for (genvar G = 0; G < rinv_pkg::RECIP_DEPTH; G++) begin : g_recip
    localparam logic [63:0] RECIP_FULL = (64'd1 << IB) / ((G < 2) ? 2 : G);
    localparam logic [IB-1:0] RECIP =
      (G < rinv_pkg::MIN_RADIX || G > rinv_pkg::MAX_RADIX) ? '0 : RECIP_FULL[IB-1:0];
    assign recip_tab[G] = RECIP;
  end

  logic [SIW-1:0] in_index;
  logic [RW-1:0]  in_radix;
  logic [BW-1:0]  base_clamped;

  logic [IB-1:0]   n;
  logic [BW-1:0]   base;
  logic [IB-1:0]   recip;
  logic [2*IB-1:0] prod;
  logic [DW-1:0]   rev;
  logic [DW-1:0]   denom;
  logic [DW-1:0]   rem;
  logic [FB-1:0]   quo;
  logic [rinv_pkg::FRACTION_W-1:0] fraction_r;

  logic [IB-1:0]    q_est;
  logic [QW-1:0]    qb;
  logic [QW-1:0]    r_raw;
  logic [IB-1:0]    q_fix;
  logic [BW-1:0]    digit;
  logic [DW+BW-1:0] rev_mul;
  logic [DW+BW-1:0] den_mul;
  logic [DW-1:0]    rev_next;
  logic [DW:0]      rem_sh;

  assign in_index = in_word[SIW-1:0];
  assign in_radix = in_word[SIW+RW-1:SIW];

  always_comb begin
    if (32'(in_radix) < rinv_pkg::MIN_RADIX) begin
      base_clamped = BW'(rinv_pkg::MIN_RADIX);
    end else if (32'(in_radix) > rinv_pkg::MAX_RADIX) begin
      base_clamped = BW'(rinv_pkg::MAX_RADIX);
    end else begin
      base_clamped = BW'(in_radix);
    end
  end

  // quotient estimate is exact or one low, fixed by one compare
  always_comb begin
    q_est = prod[2*IB-1:IB];
    qb    = QW'(q_est) * QW'(base);
    r_raw = QW'(n) - qb;
    if (r_raw >= QW'(base)) begin
      digit = BW'(r_raw - QW'(base));
      q_fix = q_est + IB'(1);
    end else begin
      digit = BW'(r_raw);
      q_fix = q_est;
    end
    rev_mul  = (DW+BW)'(rev) * (DW+BW)'(base);
    den_mul  = (DW+BW)'(denom) * (DW+BW)'(base);
    rev_next = rev_mul[DW-1:0] + DW'(digit);
    rem_sh   = {rem, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= IB'(in_index);
      base  <= base_clamped;
      recip <= recip_tab[base_clamped];
      rev   <= '0;
      denom <= DW'(1);
      rem   <= '0;
      quo   <= '0;
    end
    if (cmd.mul) begin
      prod <= (2*IB)'(n) * (2*IB)'(recip);
    end
    if (cmd.digit) begin
      n     <= q_fix;
      rev   <= rev_next;
      denom <= den_mul[DW-1:0];
      rem   <= rev_next;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, denom}) begin
        rem <= DW'(rem_sh - {1'b0, denom});
        quo <= {quo[FB-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        quo <= {quo[FB-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      fraction_r <= rinv_pkg::FRACTION_W'(quo);
    end
  end

  assign sts.n_zero = (n == '0);
  assign sts.q_zero = (q_fix == '0);
  assign fraction   = fraction_r;

endmodule

// ----- hdl/rinv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rinv_ctrl
// Sequencer for the radical inverse: input word, digit loop, divider steps
// and the output register handshake.
// ----------------------------------------------------------------------------
module rinv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  rinv_pkg::rinv_sts_t sts,
  output rinv_pkg::rinv_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIG,
    S_DIV,
    S_OUT
  } state_t;

  localparam int CW = rinv_pkg::DIV_CNT_W;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.load     = s_tvalid && s_tready;
    cmd.mul      = (state == S_MUL);
    cmd.digit    = (state == S_DIG);
    cmd.div_step = (state == S_DIV);
    cmd.out_load = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      // a new word replaces the one leaving, otherwise a taken word clears valid
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state    <= S_CHECK;
            s_tready <= 1'b0;
          end
        end
        S_CHECK: begin
          cnt   <= '0;
          state <= sts.n_zero ? S_DIV : S_MUL;
        end
        S_MUL: begin
          state <= S_DIG;
        end
        S_DIG: begin
          state <= sts.q_zero ? S_DIV : S_MUL;
        end
        S_DIV: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(rinv_pkg::FRACTION_BITS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            s_tready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state    <= S_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.digit, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_mul_then_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.digit)
    else $error("multiply not followed by digit update");

  a_out_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("output word loaded but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("pending output word overwritten");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul || cmd.digit || cmd.div_step) |-> !s_tready)
    else $error("input ready while an item is in progress");

endmodule

// ----- hdl/radical_inverse_low_discrepancy_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radical_inverse_low_discrepancy_top
// Halton radical inverse of a sample index in a base of 2 to 16, returned as
// a truncated unsigned 0.32 fixed-point fraction.
// ----------------------------------------------------------------------------
// sequencing: after input accept, a check state, then for each digit of the index
//   in the chosen base a multiply and a correction (none for index zero),
//   then the 32-step divider and the output register; a new word is taken
//   only once the result has been loaded into the output register
// reset: synchronous, clears the sequencer and empties the output register
// ----------------------------------------------------------------------------
module radical_inverse_low_discrepancy_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [30:0] sample_index, [35:31] radix, [39:36] zero
  input  logic [rinv_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] fraction
  output logic [rinv_pkg::OUT_TDATA_W-1:0] m_tdata
);

  rinv_pkg::rinv_cmd_t cmd;
  rinv_pkg::rinv_sts_t sts;
  logic [rinv_pkg::FRACTION_W-1:0] fraction;

  rinv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rinv_datapath u_datapath (
    .clk      (clk),
    .in_word  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .fraction (fraction)
  );

  assign m_tdata = rinv_pkg::OUT_TDATA_W'(fraction);

endmodule
